FILE: hdl/afk_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// afk_pkg: shared definitions for the arm forward kinematics pipeline
// Widths, fixed point constants, joint limits and rounding helpers.
// ============================================================================
package afk_pkg;

  localparam int DATA_WIDTH      = 24;
  localparam int TRIG_ITERATIONS = 16;

  // internal widths
  localparam int VW  = DATA_WIDTH + 8;                          // angle in Q.24
  localparam int KW  = (DATA_WIDTH > 20) ? DATA_WIDTH - 17 : 4; // turn count
  localparam int RWD = ((VW > 28) ? VW : 28) + 2;               // reduction work
  localparam int ZW  = 30;                                      // CORDIC angle
  localparam int TW  = 28;                                      // CORDIC x/y
  localparam int MW  = 32;                                      // Q.24 products
  localparam int LW  = 56;                                      // link sums
  localparam int PXW = (DATA_WIDTH > 30) ? DATA_WIDTH + 2 : 32; // position work

  // angle reduction, CORDIC stages, sign stage
  localparam int TRIG_LAT = TRIG_ITERATIONS + 5;

  localparam logic signed [ZW-1:0] Q24_PI      = 30'sd52707179;
  localparam logic signed [ZW-1:0] Q24_HALF_PI = 30'sd26353589;
  localparam logic signed [ZW-1:0] Q24_TWO_PI  = 30'sd105414357;
  localparam logic signed [TW-1:0] TWO_PI_K    = 28'sd105414357;
  localparam logic signed [TW-1:0] CORDIC_GAIN = 28'sd10188012;

  // floor(2^40 / two_pi) for the turn estimate
  localparam logic signed [15:0] RECIP    = 16'sd10430;
  localparam int                 RECIP_SH = 40;

  localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
    30'sd13176795, 30'sd7778716, 30'sd4110060, 30'sd2086331, 30'sd1047214,
    30'sd524117, 30'sd262123, 30'sd131069, 30'sd65536, 30'sd32768, 30'sd16384,
    30'sd8192, 30'sd4096, 30'sd2048, 30'sd1024, 30'sd512, 30'sd256, 30'sd128,
    30'sd64, 30'sd32, 30'sd16, 30'sd8, 30'sd4, 30'sd2
  };

  localparam logic signed [31:0] LOW_LIM [8] = '{
    -32'sd8192, -32'sd194449, -32'sd148696, -32'sd28595,
    -32'sd102944, -32'sd655360, -32'sd188744, 32'sd3473
  };
  localparam logic signed [31:0] HIGH_LIM [8] = '{
    32'sd79299, 32'sd194449, -32'sd57191, 32'sd45753,
    32'sd105231, 32'sd655360, 32'sd192020, 32'sd5964
  };

  localparam logic [1:0] REG_LINK_A2 = 2'd0;
  localparam logic [1:0] REG_LINK_A3 = 2'd1;
  localparam logic [1:0] REG_LINK_D5 = 2'd2;
  localparam logic [1:0] REG_GRIP_EN = 2'd3;

  localparam logic [4:0] ST_OK     = 5'd0;
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  localparam logic signed [MW-1:0] ENTRY_MAX = 32'sd65536;

  // Q.24 multiply, round half up
  function automatic logic signed [MW-1:0] mq(input logic signed [MW-1:0] a,
                                              input logic signed [MW-1:0] b);
    logic signed [2*MW-1:0] p;
    p = a * b;
    p = p + 64'sd8388608;
    return MW'(p >>> 24);
  endfunction

  function automatic logic signed [MW-1:0] rnd24(input logic signed [LW-1:0] s);
    logic signed [LW-1:0] t;
    t = s + LW'(64'sd8388608);
    return MW'(t >>> 24);
  endfunction

  function automatic logic signed [LW-1:0] lmul(input logic [19:0] len,
                                                input logic signed [MW-1:0] c);
    logic signed [LW-1:0] l;
    logic signed [LW-1:0] cc;
    l  = LW'($signed({1'b0, len}));
    cc = LW'(c);
    return l * cc;
  endfunction

  // Q.24 to Q.16 rotation entry, clamped to one
  function automatic logic signed [17:0] ent(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] r;
    r = (v + 32'sd128) >>> 8;
    if (r > ENTRY_MAX) r = ENTRY_MAX;
    if (r < -ENTRY_MAX) r = -ENTRY_MAX;
    return 18'(r);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] pos(input logic signed [PXW-1:0] v);
    logic signed [PXW-1:0] hi;
    logic signed [PXW-1:0] lo;
    logic signed [PXW-1:0] r;
    hi = $signed({{(PXW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
    lo = $signed({{(PXW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}});
    r  = v;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return DATA_WIDTH'(r);
  endfunction

endpackage

FILE: hdl/afk_trig.sv
`timescale 1ns / 1ps
// ============================================================================
// afk_trig: pipelined sine and cosine of one joint angle
// Reduces the Q8.16 angle to [-pi/2, pi/2] and runs one CORDIC step a stage.
// ============================================================================
module afk_trig (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [afk_pkg::DATA_WIDTH-1:0] angle,
  output logic signed [afk_pkg::MW-1:0]         sin_val,
  output logic signed [afk_pkg::MW-1:0]         cos_val
);
  import afk_pkg::*;

  logic signed [VW-1:0]    v;
  logic signed [VW+15:0]   kprod;
  logic signed [VW-1:0]    b_v;
  logic signed [KW-1:0]    b_k;
  logic signed [KW+TW-1:0] kmul;
  logic signed [RWD-1:0]   r0;
  logic signed [ZW-1:0]    c_r;
  logic signed [ZW-1:0]    d_r;
  logic signed [ZW-1:0]    d_r_next;
  logic signed [ZW-1:0]    r1;
  logic signed [TW-1:0]    cx [TRIG_ITERATIONS+1];
  logic signed [TW-1:0]    cy [TRIG_ITERATIONS+1];
  logic signed [ZW-1:0]    cz [TRIG_ITERATIONS+1];
  logic                    cneg [TRIG_ITERATIONS+1];

  always_comb begin
    v     = {angle, 8'd0};
    kprod = v * RECIP;
    kmul  = b_k * TWO_PI_K;
    r0    = RWD'(b_v) - RWD'(kmul);
  end

  // estimate whole turns, then subtract them
  always_ff @(posedge clk) begin
    if (en) begin
      b_v <= v;
      b_k <= KW'(kprod >>> RECIP_SH);
      c_r <= ZW'(r0);
      d_r <= d_r_next;
    end
  end

  // the turn estimate is off by at most one
  always_comb begin
    if (c_r < 0) begin
      d_r_next = c_r + Q24_TWO_PI;
    end else if (c_r >= Q24_TWO_PI) begin
      d_r_next = c_r - Q24_TWO_PI;
    end else begin
      d_r_next = c_r;
    end
    r1 = (d_r > Q24_PI) ? d_r - Q24_TWO_PI : d_r;
  end

  // fold into the CORDIC range, flip the sign of the result
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= CORDIC_GAIN;
      cy[0] <= '0;
      if (r1 > Q24_HALF_PI) begin
        cz[0]   <= r1 - Q24_PI;
        cneg[0] <= 1'b1;
      end else if (r1 < -Q24_HALF_PI) begin
        cz[0]   <= r1 + Q24_PI;
        cneg[0] <= 1'b1;
      end else begin
        cz[0]   <= r1;
        cneg[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN_TAB[i];
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN_TAB[i];
        end
        cneg[i+1] <= cneg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= MW'(cneg[TRIG_ITERATIONS] ? -cy[TRIG_ITERATIONS] : cy[TRIG_ITERATIONS]);
      cos_val <= MW'(cneg[TRIG_ITERATIONS] ? -cx[TRIG_ITERATIONS] : cx[TRIG_ITERATIONS]);
    end
  end

endmodule

FILE: hdl/arm_forward_kinematics.sv
`timescale 1ns / 1ps
// ============================================================================
// arm_forward_kinematics: end-effector frame of a seven-axis track arm
// Limit check, CORDIC trig and the 3x4 frame, emitted one row per cycle.
// ============================================================================
// A joint vector is taken when start is high and busy is low. A vector that
// breaks a joint limit gives one result with the status code and zero
// entries; any other vector gives rows 0, 1 and 2 on consecutive
// cycles, last_row marking row 2. Results leave through strobe and cannot be
// held off. The pipeline runs the limit check, the CORDIC trig lanes with
// one CORDIC step per stage, the frame products P1 to P4 and the row
// output. Sustained rate is limited by the single row output; busy rises
// while the last stage waits for the row port.
module arm_forward_kinematics (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [3:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [afk_pkg::DATA_WIDTH-1:0] track_offset,
  input  logic signed [afk_pkg::DATA_WIDTH-1:0] column_angle,
  input  logic signed [afk_pkg::DATA_WIDTH-1:0] lower_arm_angle,
  input  logic signed [afk_pkg::DATA_WIDTH-1:0] upper_arm_angle,
  input  logic signed [afk_pkg::DATA_WIDTH-1:0] wrist_tilt_angle,
  input  logic signed [afk_pkg::DATA_WIDTH-1:0] wrist_roll_angle,
  input  logic signed [afk_pkg::DATA_WIDTH-1:0] wrist_turn_angle,
  input  logic signed [afk_pkg::DATA_WIDTH-1:0] gripper_opening,
  output logic                                 strobe,
  output logic [1:0]                           row_index,
  output logic signed [17:0]                   normal_entry,
  output logic signed [17:0]                   orient_entry,
  output logic signed [17:0]                   approach_entry,
  output logic signed [afk_pkg::DATA_WIDTH-1:0] position_entry,
  output logic [4:0]                           status,
  output logic                                 last_row
);
  import afk_pkg::*;

  // configuration
  logic [19:0] link_a2;
  logic [19:0] link_a3;
  logic [19:0] link_d5;
  logic        grip_en;
  logic        cfg_wr;

  // stage A: input registers
  logic signed [DATA_WIDTH-1:0] in_q [8];
  logic signed [DATA_WIDTH-1:0] a_q [8];
  logic [4:0]                   stat_next;
  logic [4:0]                   a_stat;
  logic                         a_vld;
  logic                         en;

  // trig lanes and the matching delay line
  logic signed [MW-1:0]         sn [6];
  logic signed [MW-1:0]         cs [6];
  logic                         d_vld [TRIG_LAT];
  logic [4:0]                   d_stat [TRIG_LAT];
  logic signed [DATA_WIDTH-1:0] d_q0 [TRIG_LAT];

  // P1
  logic                         p1_vld;
  logic [4:0]                   p1_stat;
  logic signed [DATA_WIDTH-1:0] p1_q0;
  logic signed [MW-1:0] m_c1s4, m_s1s4, m_s1s5, m_c1s5, m_s1c5, m_c1c5;
  logic signed [MW-1:0] m_s4s6, m_s4c6, p1_u0, p1_u1, p1_t2, p1_e2;
  logic signed [MW-1:0] p1_c1, p1_s1, p1_c5, p1_s5, p1_c6, p1_s6;
  logic signed [LW-1:0] la2, la3, ld5, sa2, sa3, sd5;

  // P2
  logic                         p2_vld;
  logic [4:0]                   p2_stat;
  logic signed [DATA_WIDTH-1:0] p2_q0;
  logic signed [MW-1:0] p2_t0, p2_e0, p2_t1, p2_e1, p2_n2, p2_o2, p2_e2;
  logic signed [MW-1:0] p2_u0, p2_u1, p2_c1, p2_s1, p2_c6, p2_s6, p2_w, p2_pz;

  // P3
  logic                 p3_vld;
  logic [4:0]           p3_stat;
  logic signed [MW-1:0] p3_n0, p3_o0, p3_n1, p3_o1, p3_n2, p3_o2;
  logic signed [MW-1:0] p3_e0, p3_e1, p3_e2, p3_pz;
  logic signed [PXW-1:0] p3_px, p3_py;

  // P4 and row output
  logic                         p4_vld;
  logic [4:0]                   p4_stat;
  logic signed [17:0]           p4_n [3];
  logic signed [17:0]           p4_o [3];
  logic signed [17:0]           p4_a [3];
  logic signed [DATA_WIDTH-1:0] p4_p [3];
  logic                         ser_vld;
  logic [1:0]                   ser_cnt;
  logic [4:0]                   ser_stat;
  logic signed [17:0]           ser_n [3];
  logic signed [17:0]           ser_o [3];
  logic signed [17:0]           ser_a [3];
  logic signed [DATA_WIDTH-1:0] ser_p [3];
  logic                         ser_lastnow;
  logic                         viol;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_a2 <= 20'd29819;
      link_a3 <= 20'd43909;
      link_d5 <= 20'd12452;
      grip_en <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LINK_A2: link_a2 <= pwdata[19:0];
        REG_LINK_A3: link_a3 <= pwdata[19:0];
        REG_LINK_D5: link_d5 <= pwdata[19:0];
        REG_GRIP_EN: grip_en <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LINK_A2: prdata = {12'd0, link_a2};
      REG_LINK_A3: prdata = {12'd0, link_a3};
      REG_LINK_D5: prdata = {12'd0, link_d5};
      REG_GRIP_EN: prdata = {31'd0, grip_en};
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // flow control: the whole pipe holds while the last stage waits
  // --------------------------------------------------------------------------
  assign ser_lastnow = (ser_stat != ST_OK) || (ser_cnt == ROW_LAST);
  assign en          = !p4_vld || !ser_vld || ser_lastnow;
  assign busy        = !en;

  // --------------------------------------------------------------------------
  // stage A: limit check
  // --------------------------------------------------------------------------
  always_comb begin
    in_q[0] = track_offset;
    in_q[1] = column_angle;
    in_q[2] = lower_arm_angle;
    in_q[3] = upper_arm_angle;
    in_q[4] = wrist_tilt_angle;
    in_q[5] = wrist_roll_angle;
    in_q[6] = wrist_turn_angle;
    in_q[7] = gripper_opening;
  end

  // walk from the last joint down so the first violation wins
  always_comb begin
    stat_next = ST_OK;
    for (int j = 7; j >= 0; j--) begin
      if (j < 7 || grip_en) begin
        if (32'(in_q[j]) < LOW_LIM[j]) begin
          stat_next = 5'(2 * j + 1);
        end else if (32'(in_q[j]) > HIGH_LIM[j]) begin
          stat_next = 5'(2 * j + 2);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q    <= in_q;
      a_stat <= stat_next;
    end
  end

  // --------------------------------------------------------------------------
  // trig lanes, joints 1 to 6
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < 6; k++) begin : g_lane
    afk_trig u_trig (
      .clk     (clk),
      .en      (en),
      .angle   (a_q[k+1]),
      .sin_val (sn[k]),
      .cos_val (cs[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRIG_LAT; i++) d_vld[i] <= 1'b0;
    end else if (en) begin
      d_vld[0] <= a_vld;
      for (int i = 1; i < TRIG_LAT; i++) d_vld[i] <= d_vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_stat[0] <= a_stat;
      d_q0[0]   <= a_q[0];
      for (int i = 1; i < TRIG_LAT; i++) begin
        d_stat[i] <= d_stat[i-1];
        d_q0[i]   <= d_q0[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // P1..P4: frame products
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= d_vld[TRIG_LAT-1];
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // P1
      p1_stat <= d_stat[TRIG_LAT-1];
      p1_q0   <= d_q0[TRIG_LAT-1];
      m_c1s4  <= mq(cs[0], sn[3]);
      m_s1s4  <= mq(sn[0], sn[3]);
      m_s1s5  <= mq(sn[0], sn[4]);
      m_c1s5  <= mq(cs[0], sn[4]);
      m_s1c5  <= mq(sn[0], cs[4]);
      m_c1c5  <= mq(cs[0], cs[4]);
      m_s4s6  <= mq(sn[3], sn[5]);
      m_s4c6  <= mq(sn[3], cs[5]);
      p1_u0   <= mq(cs[0], cs[3]);
      p1_u1   <= mq(sn[0], cs[3]);
      p1_t2   <= mq(cs[3], cs[4]);
      p1_e2   <= mq(cs[3], sn[4]);
      la2     <= lmul(link_a2, cs[1]);
      la3     <= lmul(link_a3, cs[2]);
      ld5     <= lmul(link_d5, cs[3]);
      sa2     <= lmul(link_a2, sn[1]);
      sa3     <= lmul(link_a3, sn[2]);
      sd5     <= lmul(link_d5, sn[3]);
      p1_c1   <= cs[0];
      p1_s1   <= sn[0];
      p1_c5   <= cs[4];
      p1_s5   <= sn[4];
      p1_c6   <= cs[5];
      p1_s6   <= sn[5];

      // P2
      p2_stat <= p1_stat;
      p2_q0   <= p1_q0;
      p2_t0   <= mq(m_c1s4, p1_c5) + m_s1s5;
      p2_e0   <= mq(m_c1s4, p1_s5) - m_s1c5;
      p2_t1   <= mq(m_s1s4, p1_c5) - m_c1s5;
      p2_e1   <= mq(m_s1s4, p1_s5) + m_c1c5;
      p2_n2   <= mq(p1_t2, p1_c6) - m_s4s6;
      p2_o2   <= -mq(p1_t2, p1_s6) - m_s4c6;
      p2_e2   <= p1_e2;
      p2_w    <= rnd24(la2 + la3 + ld5);
      p2_pz   <= rnd24(-(sa2 + sa3 + sd5));
      p2_u0   <= p1_u0;
      p2_u1   <= p1_u1;
      p2_c1   <= p1_c1;
      p2_s1   <= p1_s1;
      p2_c6   <= p1_c6;
      p2_s6   <= p1_s6;

      // P3
      p3_stat <= p2_stat;
      p3_n0   <= mq(p2_t0, p2_c6) + mq(p2_u0, p2_s6);
      p3_o0   <= -mq(p2_t0, p2_s6) + mq(p2_u0, p2_c6);
      p3_n1   <= mq(p2_t1, p2_c6) + mq(p2_u1, p2_s6);
      p3_o1   <= -mq(p2_t1, p2_s6) + mq(p2_u1, p2_c6);
      p3_n2   <= p2_n2;
      p3_o2   <= p2_o2;
      p3_e0   <= p2_e0;
      p3_e1   <= p2_e1;
      p3_e2   <= p2_e2;
      p3_pz   <= p2_pz;
      p3_px   <= PXW'(mq(p2_w, p2_c1));
      p3_py   <= PXW'(mq(p2_w, p2_s1)) + PXW'(p2_q0);

      // P4: round to Q.16; a violation carries zero entries in row 0, its only row
      p4_stat <= p3_stat;
      p4_n[0] <= viol ? '0 : ent(p3_n0);
      p4_o[0] <= viol ? '0 : ent(p3_o0);
      p4_a[0] <= viol ? '0 : ent(p3_e0);
      p4_p[0] <= viol ? '0 : pos(p3_px);
      p4_n[1] <= ent(p3_n1);
      p4_o[1] <= ent(p3_o1);
      p4_a[1] <= ent(p3_e1);
      p4_p[1] <= pos(p3_py);
      p4_n[2] <= ent(p3_n2);
      p4_o[2] <= ent(p3_o2);
      p4_a[2] <= ent(p3_e2);
      p4_p[2] <= pos(PXW'(p3_pz));
    end
  end

  assign viol = (p3_stat != ST_OK);

  // --------------------------------------------------------------------------
  // row output
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_vld <= 1'b0;
      ser_cnt <= ROW_FIRST;
    end else if (p4_vld && en) begin
      ser_vld <= 1'b1;
      ser_cnt <= ROW_FIRST;
    end else if (ser_vld && ser_lastnow) begin
      ser_vld <= 1'b0;
    end else if (ser_vld) begin
      ser_cnt <= ser_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (p4_vld && en) begin
      ser_stat <= p4_stat;
      ser_n    <= p4_n;
      ser_o    <= p4_o;
      ser_a    <= p4_a;
      ser_p    <= p4_p;
    end
  end

  assign strobe         = ser_vld;
  assign row_index      = ser_cnt;
  assign normal_entry   = ser_n[ser_cnt];
  assign orient_entry   = ser_o[ser_cnt];
  assign approach_entry = ser_a[ser_cnt];
  assign position_entry = ser_p[ser_cnt];
  assign status         = ser_stat;
  assign last_row       = ser_vld && ser_lastnow;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_busy_only_on_backlog: assert property (@(posedge clk) disable iff (rst)
    !p4_vld |-> !busy)
    else $error("busy without a waiting transaction");

  a_violation_one_row: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != ST_OK) |-> last_row && (row_index == ROW_FIRST))
    else $error("limit violation not a single row");

  a_rows_consecutive: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_row |=> strobe && (row_index == $past(row_index) + 2'd1))
    else $error("frame rows not consecutive");

endmodule
